// ----- src/lctc_pkg.sv -----
// ----------------------------------------------------------------------------
// lctc_pkg
// Shared types, constants and helper functions for the Luhn card classifier.
// ----------------------------------------------------------------------------
package lctc_pkg;

  localparam int CardW      = 63;
  localparam int NumDigits  = 19;
  localparam int BcdW       = 4 * NumDigits;
  localparam int BitsPerCyc = 3;
  localparam int ConvSteps  = CardW / BitsPerCyc;
  localparam int CntW       = 5;

  typedef enum logic [1:0] {
    VerdictInvalid    = 2'd0,
    VerdictAmex       = 2'd1,
    VerdictMastercard = 2'd2,
    VerdictVisa       = 2'd3
  } verdict_e;

  typedef struct packed {
    logic            load;
    logic            conv;
    logic            scan;
    logic            finish;
    logic [CntW-1:0] pos;
  } cmd_t;

  // one double-dabble bit: add 3 to every digit above 4, then shift in msb
  function automatic logic [BcdW-1:0] dabble_bit(input logic [BcdW-1:0] bcd,
                                                 input logic            msb);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], msb};
  endfunction

  // digit sum of twice a decimal digit
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd6;
      4'd4:    r = 4'd8;
      4'd5:    r = 4'd1;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd5;
      4'd8:    r = 4'd7;
      4'd9:    r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/lctc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lctc_ctrl
// Sequencer: binary-to-BCD conversion steps, digit scan, result strobe.
// ----------------------------------------------------------------------------
module lctc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          valid_o,
  output lctc_pkg::cmd_t cmd_o
);
  import lctc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (cnt_q == CntW'(ConvSteps - 1)) begin
          cnt_d   = '0;
          state_d = StScan;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        cmd_o.pos  = cnt_q;
        if (cnt_q == CntW'(NumDigits - 1)) begin
          cnt_d   = '0;
          state_d = StFin;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy    = (state_q != StIdle);
  assign valid_o = done_q;

endmodule

// ----- src/lctc_datapath.sv -----
// ----------------------------------------------------------------------------
// lctc_datapath
// Double-dabble converter, serial digit scan with Luhn accumulator, verdict.
// ----------------------------------------------------------------------------
module lctc_datapath (
  input  logic                      clk_i,
  input  lctc_pkg::cmd_t            cmd_i,
  input  logic [lctc_pkg::CardW-1:0] card_number_i,
  output logic [1:0]                verdict_o,
  output logic                      luhn_ok_o,
  output logic [4:0]                digit_count_o
);
  import lctc_pkg::*;

  logic [CardW-1:0] bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d, bcd_c;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [3:0]       sum_q, sum_d;
  logic [3:0]       lead1_q, lead1_d;
  logic [6:0]       lead2_q, lead2_d;
  logic [3:0]       prev_q, prev_d;
  logic [1:0]       verdict_q, verdict_d;
  logic             ok_q;
  logic [4:0]       count_q;
  logic [3:0]       dig, add;
  logic [4:0]       tmp;
  logic             ok;

  always_comb begin
    bcd_c = bcd_q;
    for (int b = 0; b < BitsPerCyc; b++) begin
      bcd_c = dabble_bit(bcd_c, bin_q[CardW-1-b]);
    end
  end

  assign dig = bcd_q[3:0];
  assign add = cmd_i.pos[0] ? luhn_double(dig) : dig;
  assign tmp = {1'b0, sum_q} + {1'b0, add};
  assign ok  = (sum_q == 4'd0);

  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    lead1_d = lead1_q;
    lead2_d = lead2_q;
    prev_d  = prev_q;
    if (cmd_i.load) begin
      bin_d   = card_number_i;
      bcd_d   = '0;
      cnt_d   = '0;
      sum_d   = '0;
      lead1_d = '0;
      lead2_d = '0;
      prev_d  = '0;
    end else if (cmd_i.conv) begin
      bin_d = bin_q << BitsPerCyc;
      bcd_d = bcd_c;
    end else if (cmd_i.scan) begin
      bcd_d  = bcd_q >> 4;
      sum_d  = (tmp >= 5'd10) ? 4'(tmp - 5'd10) : tmp[3:0];
      prev_d = dig;
      if (dig != 4'd0) begin
        cnt_d   = cmd_i.pos + 1'b1;
        lead1_d = dig;
        lead2_d = {dig, 3'b000} + {2'b00, dig, 1'b0} + {3'b000, prev_q};
      end
    end
  end

  always_comb begin
    verdict_d = VerdictInvalid;
    if (ok) begin
      if (cnt_q == 5'd15 && (lead2_q == 7'd34 || lead2_q == 7'd37)) begin
        verdict_d = VerdictAmex;
      end else if (cnt_q == 5'd16 && lead2_q >= 7'd51 && lead2_q <= 7'd55) begin
        verdict_d = VerdictMastercard;
      end else if ((cnt_q == 5'd13 || cnt_q == 5'd16) && lead1_q == 4'd4) begin
        verdict_d = VerdictVisa;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    lead1_q <= lead1_d;
    lead2_q <= lead2_d;
    prev_q  <= prev_d;
    if (cmd_i.finish) begin
      verdict_q <= verdict_d;
      ok_q      <= ok;
      count_q   <= cnt_q;
    end
  end

  assign verdict_o     = verdict_q;
  assign luhn_ok_o     = ok_q;
  assign digit_count_o = count_q;

endmodule

// ----- src/luhn_card_type_classifier.sv -----
// ----------------------------------------------------------------------------
// luhn_card_type_classifier
// Luhn mod-10 check and card type verdict for one binary card number.
// ----------------------------------------------------------------------------
// start is taken only while busy is low. Each word runs through 21
// conversion steps of 3 bits each, the digit scan and the verdict step
// in the shared datapath.
// busy is high from the accepting edge until the strobe cycle.
// Reset clears the sequencer and the strobe; result ports are undefined
// until the first strobe. valid_o is high for one cycle and cannot stall.
module luhn_card_type_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [lctc_pkg::CardW-1:0] card_number_i,
  output logic                       busy,
  output logic                       valid_o,
  output logic [1:0]                 verdict_o,
  output logic                       luhn_ok_o,
  output logic [4:0]                 digit_count_o
);
  import lctc_pkg::*;

  cmd_t cmd;

  lctc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  lctc_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .card_number_i (card_number_i),
    .verdict_o     (verdict_o),
    .luhn_ok_o     (luhn_ok_o),
    .digit_count_o (digit_count_o)
  );

endmodule

// ----- src/lctc_checker.sv -----
// ----------------------------------------------------------------------------
// lctc_checker
// Port-level checks on the classifier's handshake and verdict consistency.
// ----------------------------------------------------------------------------
module lctc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic [lctc_pkg::CardW-1:0] card_number_i,
  input logic                       busy,
  input logic                       valid_o,
  input logic [1:0]                 verdict_o,
  input logic                       luhn_ok_o,
  input logic [4:0]                 digit_count_o
);
  import lctc_pkg::*;

  logic unused_card;
  assign unused_card = ^card_number_i;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted word");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy && $past(busy))
    else $error("result strobe outside end of busy period");

  a_ok_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && verdict_o != VerdictInvalid |-> luhn_ok_o)
    else $error("card verdict without passing Luhn check");

  a_len_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |->
      (verdict_o == VerdictInvalid) ||
      (verdict_o == VerdictAmex && digit_count_o == 5'd15) ||
      (verdict_o == VerdictMastercard && digit_count_o == 5'd16) ||
      (verdict_o == VerdictVisa && (digit_count_o == 5'd13 || digit_count_o == 5'd16)))
    else $error("verdict inconsistent with digit count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> digit_count_o <= 5'd19)
    else $error("digit count out of range");

endmodule

bind luhn_card_type_classifier lctc_checker u_lctc_checker (.*);
